// ===== rtl/tlrq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_pkg
// Shared widths, codes, entry type and truncation helper for the
// timestamp log range query block.
// ----------------------------------------------------------------------------
package tlrq_pkg;

    localparam int ID_W     = 16;
    localparam int TIME_W   = 40;
    localparam int FUNC_W   = 1;
    localparam int GRAN_W   = 3;
    localparam int STATUS_W = 2;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int MAX_RESULTS         = 32;
    localparam int NMATCH_W            = $clog2(MAX_RESULTS);

    localparam logic [FUNC_W-1:0] FUNC_STORE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MATCH    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd3;

    localparam logic [GRAN_W-1:0] GRAN_YEAR   = 3'd0;
    localparam logic [GRAN_W-1:0] GRAN_MONTH  = 3'd1;
    localparam logic [GRAN_W-1:0] GRAN_DAY    = 3'd2;
    localparam logic [GRAN_W-1:0] GRAN_HOUR   = 3'd3;
    localparam logic [GRAN_W-1:0] GRAN_MINUTE = 3'd4;
    localparam logic [GRAN_W-1:0] GRAN_SECOND = 3'd5;

    // low bit positions of each packed field above seconds
    localparam int YEAR_LSB   = 26;
    localparam int MONTH_LSB  = 22;
    localparam int DAY_LSB    = 17;
    localparam int HOUR_LSB   = 12;
    localparam int MINUTE_LSB = 6;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // keeps the bits that survive truncation; compare on masked values
    function automatic logic [TIME_W-1:0] trunc_mask(input logic [GRAN_W-1:0] gran);
        logic [TIME_W-1:0] ones;
        ones = '1;
        case (gran)
            GRAN_YEAR:   trunc_mask = ones << YEAR_LSB;
            GRAN_MONTH:  trunc_mask = ones << MONTH_LSB;
            GRAN_DAY:    trunc_mask = ones << DAY_LSB;
            GRAN_HOUR:   trunc_mask = ones << HOUR_LSB;
            GRAN_MINUTE: trunc_mask = ones << MINUTE_LSB;
            default:     trunc_mask = ones;
        endcase
    endfunction

endpackage

// ===== rtl/tlrq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlrq_req_if;
    import tlrq_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     log_id;
    logic [TIME_W-1:0]   time_a;
    logic [TIME_W-1:0]   time_b;
    logic [GRAN_W-1:0]   granularity;

    modport source (output valid, func, log_id, time_a, time_b, granularity, input ready);
    modport sink   (input valid, func, log_id, time_a, time_b, granularity, output ready);
endinterface

interface tlrq_rsp_if;
    import tlrq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     match_id;
    logic                last;

    modport source (output valid, status, match_id, last, input ready);
    modport sink   (input valid, status, match_id, last, output ready);
endinterface

// ===== rtl/tlrq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/timestamp_log_range_query_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_log_range_query_core
// Sorted timestamp log with insert and granularity range query.
// ----------------------------------------------------------------------------
// The log lives in one RAM of TABLE_DEPTH entries kept sorted by time, equal
// times in arrival order. A store walks the table from the top, one entry
// per cycle, moving later entries up one slot until it finds its place; a
// store to a full table is refused with a full status. A query reads the
// table from the bottom, one entry per cycle through the single read port
// while the response side accepts, and emits matching ids in time order
// with the final one marked, stopping early after MAX_RESULTS matches.
// One transaction is in flight at a time; request ready is high only while
// idle.
// ----------------------------------------------------------------------------
module timestamp_log_range_query_core #(
    parameter int TABLE_DEPTH = tlrq_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlrq_req_if.sink    i_req,
    tlrq_rsp_if.source  o_rsp
);
    import tlrq_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCMP = 3'd1;
    localparam logic [2:0] S_SPUT = 3'd2;
    localparam logic [2:0] S_RESP = 3'd3;
    localparam logic [2:0] S_QCMP = 3'd4;
    localparam logic [2:0] S_QEND = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic                r_pend_v, n_pend_v;
    logic [NMATCH_W-1:0] r_nmatch, n_nmatch;

    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic                r_out_last, n_out_last;
    logic [ID_W-1:0]     r_pend_id, n_pend_id;
    logic [STATUS_W-1:0] r_resp, n_resp;
    t_entry              r_new, n_new;
    logic [TIME_W-1:0]   r_mask, n_mask;
    logic [TIME_W-1:0]   r_lo, n_lo;
    logic [TIME_W-1:0]   r_hi, n_hi;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic [IW-1:0]       ram_raddr;
    t_entry              rd;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                accept;
    logic                out_free;
    logic [TIME_W-1:0]   rd_masked;
    logic                hit;
    logic                at_end;

    tlrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd        = t_entry'(ram_rdata);
    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign rd_masked = rd.stamp & r_mask;
    assign hit       = (rd_masked >= r_lo) && (rd_masked <= r_hi);
    assign at_end    = (CW'(r_idx) == r_count - CW'(1));

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.match_id = r_out_id;
    assign o_rsp.last     = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_pend_v     = r_pend_v;
        n_nmatch     = r_nmatch;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_last   = r_out_last;
        n_pend_id    = r_pend_id;
        n_resp       = r_resp;
        n_new        = r_new;
        n_mask       = r_mask;
        n_lo         = r_lo;
        n_hi         = r_hi;
        ram_we       = 1'b0;
        ram_waddr    = r_idx + IW'(1);
        ram_wdata    = r_new;
        ram_raddr    = r_idx;

        case (r_state)
            S_IDLE: begin
                ram_raddr = IW'(r_count - CW'(1));
                if (accept) begin
                    n_new.id    = i_req.log_id;
                    n_new.stamp = i_req.time_a;
                    n_mask      = trunc_mask(i_req.granularity);
                    n_lo        = i_req.time_a & trunc_mask(i_req.granularity);
                    n_hi        = i_req.time_b & trunc_mask(i_req.granularity);
                    if (i_req.func == FUNC_STORE) begin
                        if (r_count >= CW'(TABLE_DEPTH)) begin
                            n_resp  = ST_FULL;
                            n_state = S_RESP;
                        end else if (r_count == '0) begin
                            n_state = S_SPUT;
                        end else begin
                            n_idx   = IW'(r_count - CW'(1));
                            n_state = S_SCMP;
                        end
                    end else begin
                        ram_raddr = '0;
                        n_idx     = '0;
                        n_nmatch  = '0;
                        n_pend_v  = 1'b0;
                        n_state   = (r_count == '0) ? S_QEND : S_QCMP;
                    end
                end
            end
            S_SCMP: begin
                ram_we = 1'b1;
                if (rd.stamp > r_new.stamp) begin
                    ram_wdata = rd;
                    if (r_idx == '0) begin
                        n_state = S_SPUT;
                    end else begin
                        n_idx     = r_idx - IW'(1);
                        ram_raddr = r_idx - IW'(1);
                    end
                end else begin
                    ram_wdata = r_new;
                    n_count   = r_count + CW'(1);
                    n_resp    = ST_STORED;
                    n_state   = S_RESP;
                end
            end
            S_SPUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_new;
                n_count   = r_count + CW'(1);
                n_resp    = ST_STORED;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_resp;
                    n_out_id     = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_QCMP: begin
                if (!(hit && r_pend_v && !out_free)) begin
                    if (hit) begin
                        if (r_pend_v) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_MATCH;
                            n_out_id     = r_pend_id;
                            n_out_last   = 1'b0;
                        end
                        n_pend_v  = 1'b1;
                        n_pend_id = rd.id;
                        n_nmatch  = r_nmatch + NMATCH_W'(1);
                    end
                    if ((hit && r_nmatch == NMATCH_W'(MAX_RESULTS - 1)) || at_end) begin
                        n_state = S_QEND;
                    end else begin
                        n_idx     = r_idx + IW'(1);
                        ram_raddr = r_idx + IW'(1);
                    end
                end
            end
            S_QEND: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend_v ? ST_MATCH : ST_NO_MATCH;
                    n_out_id     = r_pend_v ? r_pend_id : '0;
                    n_out_last   = 1'b1;
                    n_pend_v     = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_pend_v    <= 1'b0;
            r_nmatch    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_pend_v    <= n_pend_v;
            r_nmatch    <= n_nmatch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_last   <= n_out_last;
        r_pend_id    <= n_pend_id;
        r_resp       <= n_resp;
        r_new        <= n_new;
        r_mask       <= n_mask;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
    end

    // entry count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // the count only ever grows by one per store
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> r_count == $past(r_count) + CW'(1))
        else $error("entry count changed by other than one");

    // only a match transaction can be followed by more results
    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_MATCH) |-> o_rsp.last)
        else $error("non-match response without last");

    // the table is never written while idle
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("table write while idle");

endmodule
